// ===== hdl/hitm_pkg.sv =====
// shared constants, codes and types of the hashed id to index map
package hitm_pkg;

  localparam int MAX_SLOTS = 4096;
  localparam int MIN_SLOTS = 16;
  localparam int SLOT_W    = $clog2(MAX_SLOTS);
  localparam int CNT_W     = SLOT_W + 1;
  localparam int KEY_W     = 64;
  localparam int IDX_W     = 11;
  localparam int CFG_W     = 13;
  localparam int ST_W      = 3;
  localparam int HALF_W    = KEY_W / 2;

  localparam logic [KEY_W-1:0] MIX_A = 64'hff51afd7ed558ccd;
  localparam logic [KEY_W-1:0] MIX_B = 64'hc4ceb9fe1a85ec53;
  localparam int MIX_SHIFT = 33;

  localparam int MOD_BITS  = 4;
  localparam int MOD_STEPS = KEY_W / MOD_BITS;
  localparam int MOD_CNT_W = $clog2(MOD_STEPS);

  localparam int FIFO_DEPTH = 2;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  localparam logic [ST_W-1:0] ST_INSERTED = 3'd0;
  localparam logic [ST_W-1:0] ST_UPDATED  = 3'd1;
  localparam logic [ST_W-1:0] ST_FULL     = 3'd2;
  localparam logic [ST_W-1:0] ST_HIT      = 3'd3;
  localparam logic [ST_W-1:0] ST_MISS     = 3'd4;

  localparam int SLOT_BITS = 1 + KEY_W + IDX_W;

  typedef struct packed {
    logic              kind;
    logic [KEY_W-1:0]  key;
    logic [IDX_W-1:0]  idx;
    logic [SLOT_W-1:0] home;
  } item_t;

  typedef struct packed {
    logic             used;
    logic [KEY_W-1:0] key;
    logic [IDX_W-1:0] idx;
  } slot_t;

endpackage

// ===== hdl/hashed_id_to_index_map.sv =====
// hashed id to index map: open addressing hash table with linear probing
//
// input channel: push a transaction (kind, node id, entry index) while full
// is low. kind insert stores or updates the key, kind lookup searches it.
// result channel: while empty is low, status and result index show the
// oldest result; pop takes it. exactly one result per transaction, in order.
// the apb port holds table_slots (address 0), the slot count in use,
// saturated to 16..4096; write it only while the block is idle.
// the front end accepts a transaction, runs the two 64x64 mix multiplies
// (three 32x32 partial products each) and the modulo (4 bits a cycle),
// then hands the transaction to a two entry queue.
// the back end probes the slot ram with a read state and a check state
// per slot visited, then issues the result.
// after reset the back end clears all 4096 slots, one per cycle, and
// full stays high while it clears them.
// a stalled receiver holds one result; the queue keeps filling behind it
// until full rises.
module hashed_id_to_index_map
  import hitm_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  output logic                    full,
  input  logic                    in_kind,
  input  logic signed [KEY_W-1:0] in_node_id,
  input  logic [IDX_W-1:0]        in_entry_index,
  output logic                    empty,
  input  logic                    pop,
  output logic [ST_W-1:0]         out_status,
  output logic [IDX_W-1:0]        out_result_index,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [2:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  logic [CFG_W-1:0] slots_r;
  logic [CNT_W-1:0] n;
  logic [31:0]      slots_w;
  logic             clearing;
  logic             q_push, q_pop, q_full, q_empty;
  item_t            q_in, q_out;

  assign pready  = 1'b1;
  assign prdata  = (paddr == 3'd0) ? 32'(slots_r) : '0;
  assign slots_w = 32'(slots_r);
  assign n = (slots_w < 32'(MIN_SLOTS)) ? CNT_W'(MIN_SLOTS) :
             (slots_w > 32'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS) : CNT_W'(slots_w);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_r <= CFG_W'(4096);
    end else if (psel && penable && pwrite && paddr == 3'd0) begin
      slots_r <= pwdata[CFG_W-1:0];
    end
  end

  hitm_hash u_hash (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_kind        (in_kind),
    .in_node_id     (in_node_id),
    .in_entry_index (in_entry_index),
    .clearing       (clearing),
    .n              (n),
    .q_push         (q_push),
    .q_full         (q_full),
    .q_item         (q_in)
  );

  hitm_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (q_push),
    .wdata   (q_in),
    .q_full  (q_full),
    .rd      (q_pop),
    .rdata   (q_out),
    .q_empty (q_empty)
  );

  hitm_probe u_probe (
    .clk              (clk),
    .rst_n            (rst_n),
    .n                (n),
    .q_empty          (q_empty),
    .q_item           (q_out),
    .q_pop            (q_pop),
    .clearing         (clearing),
    .empty            (empty),
    .pop              (pop),
    .out_status       (out_status),
    .out_result_index (out_result_index)
  );

endmodule

// ===== hdl/hitm_ram.sv =====
// generic single write port ram with registered read
module hitm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/hitm_hash.sv =====
// front end: accepts transactions and computes the home slot of the key
module hitm_hash
  import hitm_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  output logic                    full,
  input  logic                    in_kind,
  input  logic signed [KEY_W-1:0] in_node_id,
  input  logic [IDX_W-1:0]        in_entry_index,
  input  logic                    clearing,
  input  logic [CNT_W-1:0]        n,
  output logic                    q_push,
  input  logic                    q_full,
  output item_t                   q_item
);

  typedef enum logic [3:0] {
    H_IDLE = 4'b0001,
    H_MUL  = 4'b0010,
    H_MOD  = 4'b0100,
    H_PUSH = 4'b1000
  } hstate_t;

  hstate_t state_r, state_nxt;
  logic [1:0]           part_r, part_nxt;
  logic                 second_r, second_nxt;
  logic [MOD_CNT_W-1:0] mcnt_r, mcnt_nxt;

  logic [KEY_W-1:0]  x_r, x_nxt;
  logic [KEY_W-1:0]  pp_r, pp_nxt;
  logic [KEY_W-1:0]  acc_r, acc_nxt;
  logic [SLOT_W-1:0] rem_r, rem_nxt;
  logic              kind_r;
  logic [KEY_W-1:0]  key_r;
  logic [IDX_W-1:0]  idx_r;

  logic [KEY_W-1:0]  c;
  logic [KEY_W-1:0]  prod;
  logic [KEY_W-1:0]  key_u;
  logic [CNT_W-1:0]  t;
  logic [SLOT_W-1:0] r;
  logic              accept;

  assign full   = (state_r != H_IDLE) || clearing;
  assign accept = push && !full;
  assign key_u  = $unsigned(in_node_id);
  assign c      = second_r ? MIX_B : MIX_A;
  assign prod   = acc_r + {pp_r[HALF_W-1:0], {HALF_W{1'b0}}};

  assign q_push = (state_r == H_PUSH);
  assign q_item = '{kind: kind_r, key: key_r, idx: idx_r, home: rem_r};

  // remainder, several dividend bits per cycle
  always_comb begin
    r = rem_r;
    t = '0;
    for (int i = 0; i < MOD_BITS; i++) begin
      t = {r, x_r[KEY_W-1-i]};
      if (t >= n) begin
        t = t - n;
      end
      r = t[SLOT_W-1:0];
    end
  end

  always_comb begin
    state_nxt  = state_r;
    part_nxt   = part_r;
    second_nxt = second_r;
    mcnt_nxt   = mcnt_r;
    x_nxt      = x_r;
    pp_nxt     = pp_r;
    acc_nxt    = acc_r;
    rem_nxt    = rem_r;
    case (state_r)
      H_IDLE: begin
        if (accept) begin
          x_nxt      = key_u ^ (key_u >> MIX_SHIFT);
          part_nxt   = '0;
          second_nxt = 1'b0;
          state_nxt  = H_MUL;
        end
      end
      H_MUL: begin
        part_nxt = part_r + 2'd1;
        case (part_r)
          2'd0: begin
            pp_nxt = 64'(x_r[HALF_W-1:0]) * 64'(c[HALF_W-1:0]);
          end
          2'd1: begin
            acc_nxt = pp_r;
            pp_nxt  = 64'(x_r[KEY_W-1:HALF_W]) * 64'(c[HALF_W-1:0]);
          end
          2'd2: begin
            acc_nxt = prod;
            pp_nxt  = 64'(x_r[HALF_W-1:0]) * 64'(c[KEY_W-1:HALF_W]);
          end
          default: begin
            x_nxt = prod ^ (prod >> MIX_SHIFT);
            if (second_r) begin
              rem_nxt   = '0;
              mcnt_nxt  = '0;
              state_nxt = H_MOD;
            end else begin
              second_nxt = 1'b1;
            end
          end
        endcase
      end
      H_MOD: begin
        rem_nxt  = r;
        x_nxt    = x_r << MOD_BITS;
        mcnt_nxt = mcnt_r + 1'b1;
        if (mcnt_r == MOD_CNT_W'(MOD_STEPS - 1)) begin
          state_nxt = H_PUSH;
        end
      end
      H_PUSH: begin
        if (!q_full) begin
          state_nxt = H_IDLE;
        end
      end
      default: state_nxt = H_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= H_IDLE;
      part_r   <= '0;
      second_r <= 1'b0;
      mcnt_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      part_r   <= part_nxt;
      second_r <= second_nxt;
      mcnt_r   <= mcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    pp_r  <= pp_nxt;
    acc_r <= acc_nxt;
    rem_r <= rem_nxt;
    if (accept) begin
      kind_r <= in_kind;
      key_r  <= key_u;
      idx_r  <= in_entry_index;
    end
  end

endmodule

// ===== hdl/hitm_fifo.sv =====
// short queue of hashed transactions between front and back end
module hitm_fifo
  import hitm_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  wr,
  input  item_t wdata,
  output logic  q_full,
  input  logic  rd,
  output item_t rdata,
  output logic  q_empty
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);

  item_t mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wptr_r, rptr_r;
  logic [PTR_W:0]   cnt_r;
  logic do_wr, do_rd;

  assign q_full  = (cnt_r == (PTR_W+1)'(FIFO_DEPTH));
  assign q_empty = (cnt_r == '0);
  assign do_wr   = wr && !q_full;
  assign do_rd   = rd && !q_empty;
  assign rdata   = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_wr) begin
        wptr_r <= (wptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wptr_r + 1'b1;
      end
      if (do_rd) begin
        rptr_r <= (rptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rptr_r + 1'b1;
      end
      cnt_r <= cnt_r + (PTR_W+1)'(do_wr) - (PTR_W+1)'(do_rd);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wptr_r] <= wdata;
    end
  end

endmodule

// ===== hdl/hitm_probe.sv =====
// back end: clears the table after reset and walks the probe sequence
module hitm_probe
  import hitm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [CNT_W-1:0]  n,
  input  logic              q_empty,
  input  item_t             q_item,
  output logic              q_pop,
  output logic              clearing,
  output logic              empty,
  input  logic              pop,
  output logic [ST_W-1:0]   out_status,
  output logic [IDX_W-1:0]  out_result_index
);

  typedef enum logic [4:0] {
    P_CLEAR = 5'b00001,
    P_IDLE  = 5'b00010,
    P_READ  = 5'b00100,
    P_CHECK = 5'b01000,
    P_DONE  = 5'b10000
  } pstate_t;

  pstate_t state_r, state_nxt;
  logic [SLOT_W-1:0] clr_r, clr_nxt;
  logic [SLOT_W-1:0] pos_r, pos_nxt;
  logic [CNT_W-1:0]  vis_r, vis_nxt;
  item_t             it_r;
  logic [ST_W-1:0]   st_r, st_nxt;
  logic [IDX_W-1:0]  ri_r, ri_nxt;
  logic              ov_r, ov_nxt;
  logic [ST_W-1:0]   os_r;
  logic [IDX_W-1:0]  oi_r;

  logic                 we;
  logic [SLOT_W-1:0]    waddr;
  logic [SLOT_BITS-1:0] wdata;
  logic [SLOT_BITS-1:0] rdata;
  slot_t                d;
  logic [CNT_W-1:0]     pos_inc;
  logic [CNT_W-1:0]     vis_inc;
  logic                 load_out;

  hitm_ram #(.WIDTH(SLOT_BITS), .DEPTH(MAX_SLOTS)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (state_r == P_READ),
    .raddr (pos_r),
    .rdata (rdata)
  );

  assign d        = slot_t'(rdata);
  assign clearing = (state_r == P_CLEAR);
  assign q_pop    = (state_r == P_IDLE) && !q_empty;
  assign pos_inc  = {1'b0, pos_r} + 1'b1;
  assign vis_inc  = vis_r + 1'b1;
  assign load_out = (state_r == P_DONE) && (!ov_r || pop);

  assign empty            = !ov_r;
  assign out_status       = os_r;
  assign out_result_index = oi_r;

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    pos_nxt   = pos_r;
    vis_nxt   = vis_r;
    st_nxt    = st_r;
    ri_nxt    = ri_r;
    we        = 1'b0;
    waddr     = pos_r;
    wdata     = SLOT_BITS'({1'b1, it_r.key, it_r.idx});
    ov_nxt    = ov_r && !pop;
    case (state_r)
      P_CLEAR: begin
        we      = 1'b1;
        waddr   = clr_r;
        wdata   = '0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == SLOT_W'(MAX_SLOTS - 1)) begin
          state_nxt = P_IDLE;
        end
      end
      P_IDLE: begin
        if (!q_empty) begin
          pos_nxt   = q_item.home;
          vis_nxt   = '0;
          state_nxt = P_READ;
        end
      end
      P_READ: begin
        state_nxt = P_CHECK;
      end
      P_CHECK: begin
        ri_nxt    = '0;
        state_nxt = P_DONE;
        if (!d.used) begin
          if (it_r.kind == KIND_INSERT) begin
            we     = 1'b1;
            st_nxt = ST_INSERTED;
          end else begin
            st_nxt = ST_MISS;
          end
        end else if (d.key == it_r.key) begin
          if (it_r.kind == KIND_INSERT) begin
            we     = 1'b1;
            st_nxt = ST_UPDATED;
          end else begin
            st_nxt = ST_HIT;
            ri_nxt = d.idx;
          end
        end else if (vis_inc == n) begin
          st_nxt = (it_r.kind == KIND_INSERT) ? ST_FULL : ST_MISS;
        end else begin
          vis_nxt   = vis_inc;
          pos_nxt   = (pos_inc == n) ? '0 : pos_inc[SLOT_W-1:0];
          state_nxt = P_READ;
        end
      end
      P_DONE: begin
        if (load_out) begin
          ov_nxt    = 1'b1;
          state_nxt = P_IDLE;
        end
      end
      default: state_nxt = P_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= P_CLEAR;
      clr_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    vis_r <= vis_nxt;
    st_r  <= st_nxt;
    ri_r  <= ri_nxt;
    if (q_pop) begin
      it_r <= q_item;
    end
    if (load_out) begin
      os_r <= st_r;
      oi_r <= ri_r;
    end
  end

endmodule
